// ===== rtl/core/zwtd_pkg.sv =====
// Package of the ZACwire temperature decoder: word types, status codes and
// scaling constants. No dependencies.
`timescale 1ns / 1ps

package zwtd_pkg;

  // frame geometry
  localparam int unsigned FrameBits  = 20;
  localparam int unsigned PacketBits = 10;

  // reset value of the minimum strobe length
  localparam logic [7:0] MinStrobeReset = 8'd5;

  // temperature scaling: (raw * 700) / 2047 - 100
  localparam int unsigned ProdWidth  = 26;   // raw * 700 stays below 2^26
  localparam logic [9:0]  TempSpan   = 10'd700;
  localparam int unsigned RecipShift = 37;
  // ceil(2^37 / 2047); exact floor division for every dividend below 2^26
  localparam logic [26:0] Recip2047  = 27'd67141649;
  localparam int unsigned QuotWidth  = 15;
  localparam logic signed [15:0] TempOffset = 16'sd100;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_STROBE = 2'd1,
    ST_PARITY = 2'd2
  } status_e;

  typedef enum logic {
    KIND_BIT   = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] pulse_length;
  } in_word_t;

  typedef struct packed {
    status_e            status;
    logic signed [15:0] temperature;
  } out_word_t;

  // completed frame handed from the bit collector to the scaler
  typedef struct packed {
    status_e     status;
    logic [15:0] raw;
  } frame_t;

endpackage

// ===== rtl/core/zwtd_frame.sv =====
// Bit collector of the ZACwire decoder: strobe capture, data and parity
// per packet, first-error tracking. Depends on zwtd_pkg.
`timescale 1ns / 1ps

module zwtd_frame (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  zwtd_pkg::in_word_t word_i,
  input  logic [7:0]        min_strobe_i,
  output logic              done_o,
  output zwtd_pkg::frame_t  frame_o
);
  import zwtd_pkg::*;

  logic [4:0] bit_index_q, bit_index_d;
  logic [7:0] strobe_q, strobe_d;
  logic [7:0] data_q, data_d;
  logic       parity_q, parity_d;
  logic [7:0] high_q, high_d;
  status_e    error_q, error_d;

  logic       second_pkt;
  logic [4:0] pos;
  logic       bit_val;
  logic       last_bit;

  // position within the current packet
  assign second_pkt = (bit_index_q >= 5'(PacketBits));
  assign pos        = second_pkt ? (bit_index_q - 5'(PacketBits)) : bit_index_q;
  assign bit_val    = (word_i.pulse_length < strobe_q);
  assign last_bit   = (bit_index_q == 5'(FrameBits - 1));

  // next frame state
  always_comb begin
    bit_index_d = bit_index_q;
    strobe_d    = strobe_q;
    data_d      = data_q;
    parity_d    = parity_q;
    high_d      = high_q;
    error_d     = error_q;
    done_o      = 1'b0;
    frame_o     = '{status: ST_OK, raw: {high_q, data_q}};

    if (step_i) begin
      if (word_i.kind == KIND_START) begin
        bit_index_d = '0;
        strobe_d    = '0;
        data_d      = '0;
        parity_d    = 1'b0;
        high_d      = '0;
        error_d     = ST_OK;
      end else begin
        if (pos == 5'd0) begin
          strobe_d = word_i.pulse_length;
          data_d   = '0;
          parity_d = 1'b0;
          if (word_i.pulse_length < min_strobe_i && error_q == ST_OK) begin
            error_d = ST_STROBE;
          end
        end else if (pos < 5'(PacketBits - 1)) begin
          data_d   = {data_q[6:0], bit_val};
          parity_d = parity_q ^ bit_val;
        end else begin
          if ((bit_val ^ parity_q) && error_q == ST_OK) begin
            error_d = ST_PARITY;
          end
          if (!second_pkt) begin
            high_d = data_q;
          end
        end

        bit_index_d = bit_index_q + 5'd1;

        // frame end: hand over and start afresh
        if (last_bit) begin
          done_o      = 1'b1;
          frame_o     = '{status: error_d, raw: {high_q, data_q}};
          bit_index_d = '0;
          strobe_d    = '0;
          data_d      = '0;
          parity_d    = 1'b0;
          high_d      = '0;
          error_d     = ST_OK;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_index_q <= '0;
      strobe_q    <= '0;
      data_q      <= '0;
      parity_q    <= 1'b0;
      high_q      <= '0;
      error_q     <= ST_OK;
    end else begin
      bit_index_q <= bit_index_d;
      strobe_q    <= strobe_d;
      data_q      <= data_d;
      parity_q    <= parity_d;
      high_q      <= high_d;
      error_q     <= error_d;
    end
  end

  // position never runs past the last bit of a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_index_q < 5'(FrameBits))
    else $error("frame bit index out of range");

  // a completed frame always restarts at the first strobe
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (bit_index_q == 5'd0 && error_q == ST_OK))
    else $error("frame state not cleared after frame end");

endmodule

// ===== rtl/core/zwtd_scale.sv =====
// Two-stage temperature scaler of the ZACwire decoder: raw * 700, then
// division by 2047 through a reciprocal multiply. Depends on zwtd_pkg.
`timescale 1ns / 1ps

module zwtd_scale (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  zwtd_pkg::frame_t   frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output zwtd_pkg::out_word_t out_word_o
);
  import zwtd_pkg::*;

  localparam int unsigned FullWidth = ProdWidth + 27;

  logic                 s1_valid_q, s1_valid_d;
  status_e              s1_status_q;
  logic [ProdWidth-1:0] s1_prod_q;
  logic                 out_valid_q, out_valid_d;
  out_word_t            out_word_q;

  logic                 s2_free;
  logic [FullWidth-1:0] full_prod;
  logic [QuotWidth-1:0] quot;
  logic signed [15:0]   temp;

  // handshake between the stages
  assign s2_free     = !out_valid_q || out_ready_i;
  assign in_ready_o  = !s1_valid_q || s2_free;
  assign s1_valid_d  = in_ready_o ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_free ? s1_valid_q : out_valid_q;

  // reciprocal multiply and offset
  assign full_prod = FullWidth'(s1_prod_q) * FullWidth'(Recip2047);
  assign quot      = full_prod[RecipShift +: QuotWidth];
  assign temp      = (s1_status_q == ST_OK)
                   ? ($signed({1'b0, quot}) - TempOffset) : 16'sd0;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_status_q <= frame_i.status;
      s1_prod_q   <= ProdWidth'(frame_i.raw) * ProdWidth'(TempSpan);
    end
    if (s2_free && s1_valid_q) begin
      out_word_q <= '{status: s1_status_q, temperature: temp};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // an error word carries no temperature
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status != ST_OK) |-> out_word_o.temperature == 16'sd0)
    else $error("error word with nonzero temperature");

  // a good word lies within the sensor range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == ST_OK)
      |-> (out_word_o.temperature >= -16'sd100 && out_word_o.temperature <= 16'sd22310))
    else $error("temperature out of range");

  // a stalled middle stage keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_free) |=> s1_valid_q)
    else $error("middle stage word dropped");

endmodule

// ===== rtl/core/zacwire_temperature_decoder.sv =====
// ZACwire temperature decoder takes one measured pulse length per cycle
// (in_ready_o follows only output back-pressure). After its twentieth bit
// is accepted, the result of a frame passes two registers: one after the
// raw * 700 multiply and one after the reciprocal multiply by 1/2047.
// Start words clear a partial frame and give no result. The minimum strobe
// length register is written through the cfg port, which is always ready.
// Depends on zwtd_pkg, zwtd_frame and zwtd_scale.
`timescale 1ns / 1ps

module zacwire_temperature_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  zwtd_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output zwtd_pkg::out_word_t out_word_o
);
  import zwtd_pkg::*;

  logic [7:0] min_strobe_q;
  logic       in_accept;
  logic       frame_done;
  frame_t     frame;

  // minimum strobe length register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_strobe_q <= MinStrobeReset;
    end else if (cfg_valid_i) begin
      min_strobe_q <= cfg_data_i;
    end
  end

  assign in_accept = in_valid_i && in_ready_o;

  // bit collection
  zwtd_frame u_frame (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (in_accept),
    .word_i       (in_word_i),
    .min_strobe_i (min_strobe_q),
    .done_o       (frame_done),
    .frame_o      (frame)
  );

  // temperature scaling and output register
  zwtd_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (frame_done),
    .in_ready_o  (in_ready_o),
    .frame_i     (frame),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule
